### rtl/ivf_container_deframer_macros.svh
// ----------------------------------------------------------------------------
// IVF deframer assertion macros
// Concurrent check helpers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef IVF_CONTAINER_DEFRAMER_MACROS_SVH
`define IVF_CONTAINER_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IVF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IVF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IVF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define IVF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/ivfdf_pkg.sv
// ----------------------------------------------------------------------------
// IVF deframer package
// Types, codes and container constants shared by the deframer RTL.
// ----------------------------------------------------------------------------
package ivfdf_pkg;

	// parser phase
	typedef enum logic [1:0] {
		PH_FILE_HDR,
		PH_FRAME_HDR,
		PH_PAYLOAD,
		PH_REJECTED
	} phase_t;

	// per-word event code
	typedef enum logic [2:0] {
		EV_HDR_BYTE,
		EV_HDR_OK,
		EV_BAD_SIG,
		EV_BAD_CODEC,
		EV_FRM_BYTE,
		EV_FRM_DONE,
		EV_PAYLOAD,
		EV_IGNORED
	} event_t;

	// container layout
	localparam logic [31:0] FileHdrLast  = 32'd31;
	localparam logic [31:0] FrameHdrLast = 32'd11;
	localparam logic [31:0] SizeLast     = 32'd3;

	// tags, byte 0 in the low byte: "DKIF" and "AV01"
	localparam logic [31:0] SigTag   = 32'h4649_4B44;
	localparam logic [31:0] CodecTag = 32'h3130_5641;

	localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

	// input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_start;
	} in_item_t;

	// result word
	typedef struct packed {
		event_t      event_res;
		logic [7:0]  payload_byte;
		logic        last_of_frame;
		logic [31:0] frame_size;
		logic [63:0] frame_timestamp;
		logic [31:0] frame_index;
		logic        out_of_order;
		logic [15:0] pic_width;
		logic [15:0] pic_height;
		logic [31:0] timebase_num;
		logic [31:0] timebase_den;
		logic [31:0] duration;
	} res_item_t;

endpackage

### rtl/ivf_container_deframer.sv
// ----------------------------------------------------------------------------
// IVF container deframer
// Parses an AV1 IVF byte stream: file header check, frame header split,
// payload pass-through with end-of-frame marking.
// ----------------------------------------------------------------------------
// Takes one stream byte per word and returns exactly one result word per
// byte. A byte is accepted every clock cycle while the result register is
// free or being drained; its result appears in the result register on the
// cycle after acceptance (one byte per cycle sustained).
// The rate is set by the parser state (phase, position counter, frame header
// shift register, timestamp compare) being updated per accepted byte. A byte
// with stream_start set restarts the parser and is taken as header byte 0.
// After a rejected header every byte reports "ignored" until the next restart.
module ivf_container_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  ivfdf_pkg::in_item_t byte_data,
	output logic                result_valid,
	input  logic                result_stall,
	output ivfdf_pkg::res_item_t result
);
	import ivfdf_pkg::*;

	`include "ivf_container_deframer_macros.svh"

	// parser state
	phase_t      phase_q;
	logic [31:0] pos_q;
	logic        sig_bad_q;
	logic        codec_bad_q;
	logic [63:0] shift_q;
	logic [31:0] size_q;
	logic [63:0] cur_ts_q;
	logic [63:0] last_ts_q;
	logic [31:0] frames_q;
	logic        order_bad_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] tb_num_q;
	logic [31:0] tb_den_q;
	logic [31:0] dur_q;

	// result register
	logic        res_valid_q;
	res_item_t   result_q;

	// state seen by this word (reset values on restart)
	phase_t      phase_c;
	logic [31:0] pos_c;
	logic        sig_bad_c;
	logic        codec_bad_c;
	logic [63:0] shift_c;
	logic [31:0] size_c;
	logic [63:0] cur_ts_c;
	logic [63:0] last_ts_c;
	logic [31:0] frames_c;
	logic        order_bad_c;
	logic [15:0] width_c;
	logic [15:0] height_c;
	logic [31:0] tb_num_c;
	logic [31:0] tb_den_c;
	logic [31:0] dur_c;

	// next state
	phase_t      phase_n;
	logic [31:0] pos_n;
	logic        sig_bad_n;
	logic        codec_bad_n;
	logic [63:0] shift_n;
	logic [31:0] size_n;
	logic [63:0] cur_ts_n;
	logic [63:0] last_ts_n;
	logic [31:0] frames_n;
	logic        order_bad_n;
	logic [15:0] width_n;
	logic [15:0] height_n;
	logic [31:0] tb_num_n;
	logic [31:0] tb_den_n;
	logic [31:0] dur_n;

	// shared decode
	logic        accept;
	logic [7:0]  b;
	logic        sig_hit;
	logic        codec_hit;
	logic        hdr_end;
	logic        frm_end;
	logic        pay_end;
	logic [63:0] shift_in;
	logic        ts_bad;
	logic [31:0] frames_inc;

	// per-word outputs
	event_t      ev;
	logic [7:0]  pay;
	logic        last;

	assign accept     = byte_valid && !byte_stall;
	assign byte_stall = res_valid_q && result_stall;
	assign b          = byte_data.data_byte;

	// restart mux
	always_comb begin
		if (byte_data.stream_start) begin
			phase_c     = PH_FILE_HDR;
			pos_c       = '0;
			sig_bad_c   = 1'b0;
			codec_bad_c = 1'b0;
			shift_c     = '0;
			size_c      = '0;
			cur_ts_c    = '0;
			last_ts_c   = '0;
			frames_c    = '0;
			order_bad_c = 1'b0;
			width_c     = '0;
			height_c    = '0;
			tb_num_c    = '0;
			tb_den_c    = '0;
			dur_c       = '0;
		end else begin
			phase_c     = phase_q;
			pos_c       = pos_q;
			sig_bad_c   = sig_bad_q;
			codec_bad_c = codec_bad_q;
			shift_c     = shift_q;
			size_c      = size_q;
			cur_ts_c    = cur_ts_q;
			last_ts_c   = last_ts_q;
			frames_c    = frames_q;
			order_bad_c = order_bad_q;
			width_c     = width_q;
			height_c    = height_q;
			tb_num_c    = tb_num_q;
			tb_den_c    = tb_den_q;
			dur_c       = dur_q;
		end
	end

	// tag compares and end-of-section detects
	assign sig_hit   = (pos_c < 32'd4) && (b != SigTag[8*pos_c[1:0] +: 8]);
	assign codec_hit = (pos_c >= 32'd8) && (pos_c < 32'd12)
		&& (b != CodecTag[8*pos_c[1:0] +: 8]);
	assign hdr_end   = pos_c >= FileHdrLast;
	assign frm_end   = pos_c >= FrameHdrLast;
	assign pay_end   = (size_c == '0) || (pos_c >= size_c - 32'd1);
	assign shift_in  = {b, shift_c[63:8]};
	assign ts_bad    = (frames_c != '0) && (shift_in <= last_ts_c);
	assign frames_inc = (frames_c != CountMax) ? frames_c + 32'd1 : frames_c;

	// next-state logic
	always_comb begin
		phase_n     = phase_c;
		pos_n       = pos_c;
		sig_bad_n   = sig_bad_c;
		codec_bad_n = codec_bad_c;
		shift_n     = shift_c;
		size_n      = size_c;
		cur_ts_n    = cur_ts_c;
		last_ts_n   = last_ts_c;
		frames_n    = frames_c;
		order_bad_n = order_bad_c;
		width_n     = width_c;
		height_n    = height_c;
		tb_num_n    = tb_num_c;
		tb_den_n    = tb_den_c;
		dur_n       = dur_c;
		unique case (phase_c)
			PH_FILE_HDR: begin
				sig_bad_n   = sig_bad_c || sig_hit;
				codec_bad_n = codec_bad_c || codec_hit;
				// little-endian header fields, bytes 12 to 27
				if (pos_c >= 32'd12 && pos_c < 32'd14) begin
					width_n[8*pos_c[0] +: 8] = b;
				end else if (pos_c >= 32'd14 && pos_c < 32'd16) begin
					height_n[8*pos_c[0] +: 8] = b;
				end else if (pos_c >= 32'd16 && pos_c < 32'd20) begin
					tb_num_n[8*pos_c[1:0] +: 8] = b;
				end else if (pos_c >= 32'd20 && pos_c < 32'd24) begin
					tb_den_n[8*pos_c[1:0] +: 8] = b;
				end else if (pos_c >= 32'd24 && pos_c < 32'd28) begin
					dur_n[8*pos_c[1:0] +: 8] = b;
				end
				if (hdr_end) begin
					pos_n = '0;
					if (sig_bad_n || codec_bad_n) begin
						phase_n = PH_REJECTED;
					end else begin
						phase_n = PH_FRAME_HDR;
					end
				end else begin
					pos_n = pos_c + 32'd1;
				end
			end
			PH_FRAME_HDR: begin
				shift_n = shift_in;
				if (pos_c == SizeLast) begin
					size_n = shift_in[63:32];
				end
				if (frm_end) begin
					order_bad_n = order_bad_c || ts_bad;
					last_ts_n   = shift_in;
					cur_ts_n    = shift_in;
					pos_n       = '0;
					if (size_c == '0) begin
						frames_n = frames_inc;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end else begin
					pos_n = pos_c + 32'd1;
				end
			end
			PH_PAYLOAD: begin
				if (pay_end) begin
					pos_n    = '0;
					phase_n  = PH_FRAME_HDR;
					frames_n = frames_inc;
				end else begin
					pos_n = pos_c + 32'd1;
				end
			end
			PH_REJECTED: begin
				phase_n = PH_REJECTED;
			end
			default: begin
				phase_n = phase_c;
			end
		endcase
	end

	// per-word event, payload and end mark
	always_comb begin
		ev   = EV_IGNORED;
		pay  = '0;
		last = 1'b0;
		unique case (phase_c)
			PH_FILE_HDR: begin
				if (!hdr_end) begin
					ev = EV_HDR_BYTE;
				end else if (sig_bad_c || sig_hit) begin
					ev = EV_BAD_SIG;
				end else if (codec_bad_c || codec_hit) begin
					ev = EV_BAD_CODEC;
				end else begin
					ev = EV_HDR_OK;
				end
			end
			PH_FRAME_HDR: begin
				if (frm_end) begin
					ev   = EV_FRM_DONE;
					last = (size_c == '0);
				end else begin
					ev = EV_FRM_BYTE;
				end
			end
			PH_PAYLOAD: begin
				ev   = EV_PAYLOAD;
				pay  = b;
				last = pay_end;
			end
			PH_REJECTED: begin
				ev = EV_IGNORED;
			end
			default: begin
				ev = EV_IGNORED;
			end
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FILE_HDR;
			pos_q       <= '0;
			sig_bad_q   <= 1'b0;
			codec_bad_q <= 1'b0;
			shift_q     <= '0;
			size_q      <= '0;
			cur_ts_q    <= '0;
			last_ts_q   <= '0;
			frames_q    <= '0;
			order_bad_q <= 1'b0;
			width_q     <= '0;
			height_q    <= '0;
			tb_num_q    <= '0;
			tb_den_q    <= '0;
			dur_q       <= '0;
		end else if (accept) begin
			phase_q     <= phase_n;
			pos_q       <= pos_n;
			sig_bad_q   <= sig_bad_n;
			codec_bad_q <= codec_bad_n;
			shift_q     <= shift_n;
			size_q      <= size_n;
			cur_ts_q    <= cur_ts_n;
			last_ts_q   <= last_ts_n;
			frames_q    <= frames_n;
			order_bad_q <= order_bad_n;
			width_q     <= width_n;
			height_q    <= height_n;
			tb_num_q    <= tb_num_n;
			tb_den_q    <= tb_den_n;
			dur_q       <= dur_n;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.event_res       <= ev;
			result_q.payload_byte    <= pay;
			result_q.last_of_frame   <= last;
			result_q.frame_size      <= size_n;
			result_q.frame_timestamp <= cur_ts_n;
			result_q.frame_index     <= frames_c;
			result_q.out_of_order    <= order_bad_n;
			result_q.pic_width       <= width_n;
			result_q.pic_height      <= height_n;
			result_q.timebase_num    <= tb_num_n;
			result_q.timebase_den    <= tb_den_n;
			result_q.duration        <= dur_n;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

	// checks
	`IVF_ASSERT_NEXT(a_rejected_sticks, clk, arst_n,
		accept && !byte_data.stream_start && phase_q == PH_REJECTED,
		phase_q == PH_REJECTED, "rejected phase left without restart")
	`IVF_ASSERT_IMPL(a_hdr_pos_range, clk, arst_n,
		phase_q == PH_FILE_HDR, pos_q <= FileHdrLast,
		"file header position out of range")
	`IVF_ASSERT_IMPL(a_last_on_frame_event, clk, arst_n,
		res_valid_q && result_q.last_of_frame,
		result_q.event_res == EV_PAYLOAD || result_q.event_res == EV_FRM_DONE,
		"end-of-frame mark on a non-frame event")

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// IVF container deframer testbench
// Drives IVF streams byte by byte into the deframer and checks every result
// word against a cycle-free model of the parser kept in a scoreboard: header
// verdicts, frame splitting, payload marking, timestamp order and the
// gathered header fields. Runs a directed set of edge streams, then random
// streams under four handshake pressure phases.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ivfdf_pkg::*;

	// stream shapes and header fill patterns
	localparam int HDR_GOOD      = 0;
	localparam int HDR_BAD_SIG   = 1;
	localparam int HDR_BAD_CODEC = 2;
	localparam int HDR_BAD_BOTH  = 3;
	localparam int HDR_NOISE     = 4;
	localparam int FILL_RANDOM   = 0;
	localparam int FILL_ZEROS    = 1;
	localparam int FILL_ONES     = 2;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_BYTES   = 400;

	// Scoreboard: tracks parser state per accepted word, checks results in order
	class ivf_parse_board;
		phase_t      ph;
		logic [31:0] pos;
		bit          sig_bad;
		bit          codec_bad;
		logic [63:0] shift_acc;
		logic [31:0] cur_size;
		logic [63:0] cur_ts;
		logic [63:0] prev_ts;
		logic [31:0] frame_count;
		bit          ts_disorder;
		logic [31:0] hdr_field [5];
		res_item_t   due_results [$];
		int unsigned tally [8];
		int unsigned n_checked;
		int unsigned failures;

		function new();
			foreach (tally[i])
				tally[i] = 0;
			n_checked = 0;
			failures = 0;
			restart();
		endfunction

		function void restart();
			ph = PH_FILE_HDR;
			pos = '0;
			sig_bad = 1'b0;
			codec_bad = 1'b0;
			shift_acc = '0;
			cur_size = '0;
			cur_ts = '0;
			prev_ts = '0;
			frame_count = '0;
			ts_disorder = 1'b0;
			foreach (hdr_field[i])
				hdr_field[i] = '0;
		endfunction

		function void bump_frames();
			if (frame_count != CountMax)
				frame_count++;
		endfunction

		// accepted input word: advance the parser and queue its result
		function void note_byte(in_item_t w);
			res_item_t   r;
			logic [7:0]  b;
			int          slot;
			int          base;
			if (w.stream_start)
				restart();
			b = w.data_byte;
			r = '0;
			r.event_res = EV_IGNORED;
			r.frame_index = frame_count;
			case (ph)
			PH_FILE_HDR: begin
				if (pos < 4 && b != SigTag[8*pos[1:0] +: 8])
					sig_bad = 1'b1;
				if (pos >= 8 && pos < 12 && b != CodecTag[8*pos[1:0] +: 8])
					codec_bad = 1'b1;
				// little-endian header fields live in bytes 12..27
				if (pos >= 12 && pos <= 27) begin
					if (pos < 14) begin
						slot = 0; base = 12;
					end else if (pos < 16) begin
						slot = 1; base = 14;
					end else if (pos < 20) begin
						slot = 2; base = 16;
					end else if (pos < 24) begin
						slot = 3; base = 20;
					end else begin
						slot = 4; base = 24;
					end
					hdr_field[slot][8*(pos-base) +: 8] = b;
				end
				if (pos >= FileHdrLast) begin
					pos = '0;
					// signature failure wins over codec failure
					if (sig_bad) begin
						r.event_res = EV_BAD_SIG;
						ph = PH_REJECTED;
					end else if (codec_bad) begin
						r.event_res = EV_BAD_CODEC;
						ph = PH_REJECTED;
					end else begin
						r.event_res = EV_HDR_OK;
						ph = PH_FRAME_HDR;
					end
				end else begin
					r.event_res = EV_HDR_BYTE;
					pos++;
				end
			end
			PH_FRAME_HDR: begin
				shift_acc = {b, shift_acc[63:8]};
				if (pos == SizeLast)
					cur_size = shift_acc[63:32];
				if (pos >= FrameHdrLast) begin
					// first frame is never compared
					if (frame_count != 0 && shift_acc <= prev_ts)
						ts_disorder = 1'b1;
					prev_ts = shift_acc;
					cur_ts = shift_acc;
					pos = '0;
					r.event_res = EV_FRM_DONE;
					if (cur_size == 0) begin
						r.last_of_frame = 1'b1;
						bump_frames();
					end else begin
						ph = PH_PAYLOAD;
					end
				end else begin
					r.event_res = EV_FRM_BYTE;
					pos++;
				end
			end
			PH_PAYLOAD: begin
				r.event_res = EV_PAYLOAD;
				r.payload_byte = b;
				if (cur_size == 0 || pos >= cur_size - 1) begin
					r.last_of_frame = 1'b1;
					pos = '0;
					ph = PH_FRAME_HDR;
					bump_frames();
				end else begin
					pos++;
				end
			end
			default: begin
				r.event_res = EV_IGNORED;
			end
			endcase
			r.frame_size = cur_size;
			r.frame_timestamp = cur_ts;
			r.out_of_order = ts_disorder;
			r.pic_width = hdr_field[0][15:0];
			r.pic_height = hdr_field[1][15:0];
			r.timebase_num = hdr_field[2];
			r.timebase_den = hdr_field[3];
			r.duration = hdr_field[4];
			due_results.push_back(r);
		endfunction

		function void flag(string what, logic [63:0] want, logic [63:0] seen);
			failures++;
			if (failures <= 10)
				$display("mismatch %s at result %0d: expected %h, actual %h",
					what, n_checked, want, seen);
		endfunction

		// accepted result word: compare with the oldest expectation
		function void check_result(res_item_t got);
			res_item_t want;
			if (due_results.size() == 0) begin
				flag("unexpected result, event", '0, got.event_res);
				return;
			end
			want = due_results.pop_front();
			n_checked++;
			tally[want.event_res]++;
			if (got.event_res !== want.event_res)
				flag("event_res", want.event_res, got.event_res);
			if (got.payload_byte !== want.payload_byte)
				flag("payload_byte", want.payload_byte, got.payload_byte);
			if (got.last_of_frame !== want.last_of_frame)
				flag("last_of_frame", want.last_of_frame, got.last_of_frame);
			if (got.frame_size !== want.frame_size)
				flag("frame_size", want.frame_size, got.frame_size);
			if (got.frame_timestamp !== want.frame_timestamp)
				flag("frame_timestamp", want.frame_timestamp, got.frame_timestamp);
			if (got.frame_index !== want.frame_index)
				flag("frame_index", want.frame_index, got.frame_index);
			if (got.out_of_order !== want.out_of_order)
				flag("out_of_order", want.out_of_order, got.out_of_order);
			if (got.pic_width !== want.pic_width)
				flag("pic_width", want.pic_width, got.pic_width);
			if (got.pic_height !== want.pic_height)
				flag("pic_height", want.pic_height, got.pic_height);
			if (got.timebase_num !== want.timebase_num)
				flag("timebase_num", want.timebase_num, got.timebase_num);
			if (got.timebase_den !== want.timebase_den)
				flag("timebase_den", want.timebase_den, got.timebase_den);
			if (got.duration !== want.duration)
				flag("duration", want.duration, got.duration);
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	in_item_t   byte_data = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	res_item_t  result;

	ivf_parse_board board;
	logic [7:0]     stream_buf [$];
	int             idle_pct = 0;
	int             stall_pct = 0;
	int unsigned    bytes_sent = 0;
	int unsigned    streams_sent = 0;
	int             quiet_cycles;

	ivf_container_deframer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver backpressure
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_result(result);
	end

	// watchdog: too long without any word moving
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((byte_valid && !byte_stall) || (result_valid && !result_stall)))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// one input word, with optional idle cycles ahead of it
	task automatic send_byte(input in_item_t w);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < idle_pct);
		end
		byte_valid <= 1'b1;
		byte_data <= w;
		do begin
			@(posedge clk);
		end while (byte_stall);
		board.note_byte(w);
		bytes_sent++;
	endtask

	task automatic hold_until_drained();
		byte_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (board.due_results.size() != 0);
	endtask

	// 32-byte file header; tags optionally corrupted
	function automatic void add_header(input int mode, input int fill);
		logic [7:0] b;
		int         at;
		at = stream_buf.size();
		for (int i = 0; i < 32; i++) begin
			if (i < 4)
				b = SigTag[8*i +: 8];
			else if (i >= 8 && i < 12)
				b = CodecTag[8*(i-8) +: 8];
			else if (fill == FILL_ZEROS)
				b = 8'h00;
			else if (fill == FILL_ONES)
				b = 8'hFF;
			else
				b = 8'($urandom_range(255));
			stream_buf.push_back(b);
		end
		if (mode == HDR_BAD_SIG || mode == HDR_BAD_BOTH) begin
			at = at + $urandom_range(3);
			stream_buf[at] = stream_buf[at] ^ 8'($urandom_range(1, 255));
		end
		if (mode == HDR_BAD_CODEC || mode == HDR_BAD_BOTH) begin
			at = stream_buf.size() - 32 + 8 + $urandom_range(3);
			stream_buf[at] = stream_buf[at] ^ 8'($urandom_range(1, 255));
		end
	endfunction

	// frame header plus n_pay payload bytes (n_pay < size truncates the frame)
	function automatic void add_frame(input logic [31:0] size, input logic [63:0] ts,
		input int n_pay);
		for (int i = 0; i < 4; i++)
			stream_buf.push_back(size[8*i +: 8]);
		for (int i = 0; i < 8; i++)
			stream_buf.push_back(ts[8*i +: 8]);
		for (int i = 0; i < n_pay; i++)
			stream_buf.push_back(8'($urandom_range(255)));
	endfunction

	function automatic void add_ignored(input int n);
		for (int i = 0; i < n; i++)
			stream_buf.push_back(8'($urandom_range(255)));
	endfunction

	// send the first n bytes of the buffer, restart flag on the first
	task automatic send_stream(input int n);
		in_item_t w;
		for (int i = 0; i < n; i++) begin
			w.data_byte = stream_buf[i];
			w.stream_start = (i == 0);
			send_byte(w);
		end
		streams_sent++;
		stream_buf.delete();
	endtask

	task automatic directed_streams();
		// all-ones header fields; empty first frame at ts 0, equal and falling
		// timestamps, max timestamp, and a max-size frame cut by a restart
		add_header(HDR_GOOD, FILL_ONES);
		add_frame(32'd0, 64'd0, 0);
		add_frame(32'd1, 64'd7, 1);
		add_frame(32'd2, 64'd7, 2);
		add_frame(32'd0, 64'd2, 0);
		add_frame(32'd3, 64'hFFFF_FFFF_FFFF_FFFF, 3);
		add_frame(32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 3);
		send_stream(stream_buf.size());
		// all-zero fields, restart in the middle of the file header
		add_header(HDR_GOOD, FILL_ZEROS);
		send_stream(20);
		// rejected headers, then bytes that are ignored
		add_header(HDR_BAD_SIG, FILL_RANDOM);
		stream_buf.push_back(8'h00);
		stream_buf.push_back(8'hFF);
		send_stream(stream_buf.size());
		add_header(HDR_BAD_CODEC, FILL_RANDOM);
		add_ignored(3);
		send_stream(stream_buf.size());
		add_header(HDR_BAD_BOTH, FILL_RANDOM);
		add_ignored(3);
		send_stream(stream_buf.size());
	endtask

	task automatic random_stream();
		int          pick;
		int          mode;
		int          n_frames;
		int          n_pay;
		int          len;
		logic [31:0] size;
		logic [63:0] ts;
		bit          cut;
		pick = $urandom_range(99);
		mode = pick < 78 ? HDR_GOOD : pick < 84 ? HDR_BAD_SIG :
			pick < 90 ? HDR_BAD_CODEC : pick < 95 ? HDR_BAD_BOTH : HDR_NOISE;
		if (mode == HDR_NOISE) begin
			add_ignored($urandom_range(1, 60));
		end else begin
			pick = $urandom_range(99);
			add_header(mode, pick < 90 ? FILL_RANDOM : pick < 95 ? FILL_ZEROS : FILL_ONES);
		end
		if (mode == HDR_GOOD) begin
			n_frames = $urandom_range(1, 8);
			ts = ($urandom_range(1) != 0) ? 64'($urandom_range(100)) : {$urandom, $urandom};
			cut = 1'b0;
			for (int f = 0; f < n_frames && !cut; f++) begin
				// mostly rising timestamps, some repeats, drops and jumps
				if (f != 0) begin
					pick = $urandom_range(99);
					if (pick < 80)
						ts = ts + 64'($urandom_range(1, 5000));
					else if (pick < 88)
						ts = ts;
					else if (pick < 95)
						ts = ts - 64'($urandom_range(1, 100));
					else
						ts = {$urandom, $urandom};
				end
				pick = $urandom_range(99);
				if (pick < 15) begin
					size = '0;
				end else if (pick < 90) begin
					size = $urandom_range(1, 24);
				end else if (pick < 97) begin
					size = $urandom_range(25, 300);
				end else begin
					// too long to finish: a few bytes, then the next stream restarts
					size = $urandom | 32'h0000_1000;
					cut = 1'b1;
				end
				n_pay = cut ? $urandom_range(0, 16) : int'(size);
				add_frame(size, ts, n_pay);
			end
		end else if (mode != HDR_NOISE) begin
			add_ignored($urandom_range(1, 6));
		end
		len = stream_buf.size();
		if (len > 1 && $urandom_range(99) < 8)
			len = $urandom_range(1, len - 1);
		send_stream(len);
	endtask

	initial begin
		int unsigned mark;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		directed_streams();
		// handshake phases: free flow, sender gaps, receiver stalls, both
		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin
				idle_pct = 0; stall_pct = 0;
			end
			1: begin
				idle_pct = 62; stall_pct = 0;
			end
			2: begin
				idle_pct = 0; stall_pct = 62;
			end
			default: begin
				idle_pct = 16; stall_pct = 16;
			end
			endcase
			hold_until_drained();
			mark = bytes_sent;
			while (bytes_sent - mark < PHASE_BYTES)
				random_stream();
		end
		hold_until_drained();
		repeat (4) @(posedge clk);
		$display("Run: %0d bytes in %0d streams, %0d results checked, %0d mismatches.",
			bytes_sent, streams_sent, board.n_checked, board.failures);
		$display("Seen: %0d headers accepted, %0d rejected, %0d frames, %0d payload, %0d ignored.",
			board.tally[EV_HDR_OK], board.tally[EV_BAD_SIG] + board.tally[EV_BAD_CODEC],
			board.tally[EV_FRM_DONE], board.tally[EV_PAYLOAD], board.tally[EV_IGNORED]);
		if (board.failures == 0 && board.due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
